// ===== src/gsap_pkg.sv =====
package gsap_pkg;

    // field widths
    localparam int ASC_W      = 8;
    localparam int LH_W       = 8;
    localparam int DIM_W      = 10;
    localparam int GW_W       = 8;
    localparam int GH_W       = 8;
    localparam int BT_W       = 8;
    localparam int ADV_W      = 15;
    localparam int PAGE_W     = 8;
    localparam int POSX_W     = 9;
    localparam int POSY_W     = 10;
    localparam int CELLW_W    = 8;
    localparam int CELLH_W    = 10;
    localparam int YOFF_W     = 9;
    localparam int ADVPX_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // placement arithmetic width, holds shelf_y + shelf_height + 1 + cell_height
    localparam int SUM_W = 12;

    localparam int MAX_ATLAS_DIM_DEF = 512;
    localparam int PAGE_BITS_DEF     = 8;
    localparam int MIN_ATLAS_DIM     = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASCENDER     = 2'd0,
        CFG_LINE_HEIGHT  = 2'd1,
        CFG_ATLAS_WIDTH  = 2'd2,
        CFG_ATLAS_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ASC_W-1:0] ascender;
        logic [LH_W-1:0]  line_height;
        logic [DIM_W-1:0] atlas_width;
        logic [DIM_W-1:0] atlas_height;
    } t_cfg;

    // classified glyph, as queued between front and back
    typedef struct packed {
        logic               blank;
        logic [CELLW_W-1:0] cell_width;
        logic [CELLH_W-1:0] cell_height;
        logic [YOFF_W-1:0]  y_offset;
        logic [ADVPX_W-1:0] advance_px;
    } t_cls;

    localparam int CLS_W = $bits(t_cls);

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [POSX_W-1:0]  pos_x;
        logic [POSY_W-1:0]  pos_y;
        logic [CELLW_W-1:0] cell_width;
        logic [CELLH_W-1:0] cell_height;
        logic [YOFF_W-1:0]  y_offset;
        logic [ADVPX_W-1:0] advance_px;
        logic               new_page;
        logic               blank;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== src/gsap_if.sv =====
interface glyph_in_if;
    logic                           valid;
    logic                           ready;
    logic [gsap_pkg::GW_W-1:0]      glyph_width;
    logic [gsap_pkg::GH_W-1:0]      glyph_height;
    logic signed [gsap_pkg::BT_W-1:0] bearing_top;
    logic [gsap_pkg::ADV_W-1:0]     advance_raw;

    modport source(output valid, glyph_width, glyph_height, bearing_top, advance_raw,
                   input ready);
    modport sink(input valid, glyph_width, glyph_height, bearing_top, advance_raw,
                 output ready);
endinterface

interface place_out_if;
    logic                             valid;
    logic                             ready;
    logic [gsap_pkg::PAGE_W-1:0]      page;
    logic [gsap_pkg::POSX_W-1:0]      pos_x;
    logic [gsap_pkg::POSY_W-1:0]      pos_y;
    logic [gsap_pkg::CELLW_W-1:0]     cell_width;
    logic [gsap_pkg::CELLH_W-1:0]     cell_height;
    logic [gsap_pkg::YOFF_W-1:0]      y_offset;
    logic [gsap_pkg::ADVPX_W-1:0]     advance_px;
    logic                             new_page;
    logic                             blank;

    modport source(output valid, page, pos_x, pos_y, cell_width, cell_height, y_offset,
                          advance_px, new_page, blank,
                   input ready);
    modport sink(input valid, page, pos_x, pos_y, cell_width, cell_height, y_offset,
                       advance_px, new_page, blank,
                 output ready);
endinterface

// ===== src/gsap_front.sv =====
module gsap_front (
    glyph_in_if.sink         i_in,
    input  gsap_pkg::t_cfg   i_cfg,
    input  gsap_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output gsap_pkg::t_cls   o_cls
);
    import gsap_pkg::*;

    logic signed [YOFF_W+1:0] yo;
    logic [YOFF_W-1:0]        y_off;
    logic [CELLH_W-1:0]       cell_sum;
    logic [CELLH_W-1:0]       lh_ext;
    logic [ADV_W:0]           adv_sum;
    logic                     is_blank;

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        // ascender minus signed bearing, floored at zero
        yo       = $signed({3'b000, i_cfg.ascender}) - $signed({{3{i_in.bearing_top[BT_W-1]}},
                                                             i_in.bearing_top});
        y_off    = yo[YOFF_W+1] ? '0 : yo[YOFF_W-1:0];
        lh_ext   = CELLH_W'(i_cfg.line_height);
        cell_sum = CELLH_W'(y_off) + CELLH_W'(i_in.glyph_height);
        adv_sum  = {1'b0, i_in.advance_raw} + (ADV_W+1)'(63);
        is_blank = (i_in.glyph_width == '0) || (i_in.glyph_height == '0);

        o_cls.blank      = is_blank;
        o_cls.advance_px = adv_sum[ADV_W:6];
        if (is_blank) begin
            o_cls.cell_width  = '0;
            o_cls.cell_height = lh_ext;
            o_cls.y_offset    = '0;
        end else begin
            o_cls.cell_width  = i_in.glyph_width;
            o_cls.cell_height = (cell_sum < lh_ext) ? lh_ext : cell_sum;
            o_cls.y_offset    = y_off;
        end
    end

endmodule

// ===== src/gsap_queue.sv =====
module gsap_queue #(
    parameter int WIDTH = gsap_pkg::CLS_W,
    parameter int DEPTH = gsap_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output gsap_pkg::t_q_stat o_stat
);
    import gsap_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== src/gsap_back.sv =====
module gsap_back #(
    parameter int MAX_ATLAS_DIM = gsap_pkg::MAX_ATLAS_DIM_DEF,
    parameter int PAGE_BITS     = gsap_pkg::PAGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsap_pkg::t_cfg    i_cfg,
    input  gsap_pkg::t_q_stat i_q_stat,
    input  gsap_pkg::t_cls    i_cls,
    output logic              o_pop,
    place_out_if.source       o_out
);
    import gsap_pkg::*;

    localparam logic [SUM_W-1:0] DIM_HI = SUM_W'(MAX_ATLAS_DIM);
    localparam logic [SUM_W-1:0] DIM_LO = SUM_W'(MIN_ATLAS_DIM);

    logic [DIM_W-1:0]     r_shelf_x, n_shelf_x;
    logic [DIM_W-1:0]     r_shelf_y, n_shelf_y;
    logic [DIM_W-1:0]     r_shelf_h, n_shelf_h;
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_out_valid;
    t_res                 r_out, n_out;

    logic [SUM_W-1:0] aw, ah, aw_m1, ah_m1;
    logic [SUM_W-1:0] x_sum, ny, y_sum;
    logic             wrap, page_ovf, fire;
    logic [DIM_W-1:0] place_x, place_y, base_h;

    assign fire  = !i_q_stat.empty && (!r_out_valid || o_out.ready);
    assign o_pop = fire;

    always_comb begin
        aw = SUM_W'(i_cfg.atlas_width);
        ah = SUM_W'(i_cfg.atlas_height);
        if (aw < DIM_LO) begin
            aw = DIM_LO;
        end else if (aw > DIM_HI) begin
            aw = DIM_HI;
        end
        if (ah < DIM_LO) begin
            ah = DIM_LO;
        end else if (ah > DIM_HI) begin
            ah = DIM_HI;
        end
        aw_m1 = aw - 1'b1;
        ah_m1 = ah - 1'b1;

        // row full: open a shelf below the tallest cell, maybe a new page
        x_sum    = SUM_W'(r_shelf_x) + SUM_W'(i_cls.cell_width);
        wrap     = (x_sum >= aw_m1);
        ny       = SUM_W'(r_shelf_y) + SUM_W'(r_shelf_h) + 1'b1;
        y_sum    = ny + SUM_W'(i_cls.cell_height);
        page_ovf = wrap && (y_sum >= ah_m1);

        place_x = wrap ? '0 : r_shelf_x;
        base_h  = wrap ? '0 : r_shelf_h;
        if (!wrap) begin
            place_y = r_shelf_y;
        end else if (page_ovf) begin
            place_y = '0;
        end else begin
            place_y = ny[DIM_W-1:0];
        end

        n_shelf_x = place_x + DIM_W'(i_cls.cell_width);
        n_shelf_y = place_y;
        n_shelf_h = (base_h < i_cls.cell_height) ? i_cls.cell_height : base_h;
        n_page    = (page_ovf && (r_page != '1)) ? r_page + 1'b1 : r_page;

        n_out.cell_width  = i_cls.cell_width;
        n_out.cell_height = i_cls.cell_height;
        n_out.y_offset    = i_cls.y_offset;
        n_out.advance_px  = i_cls.advance_px;
        n_out.blank       = i_cls.blank;
        if (i_cls.blank) begin
            n_out.page     = PAGE_W'(r_page);
            n_out.pos_x    = '0;
            n_out.pos_y    = '0;
            n_out.new_page = 1'b0;
        end else begin
            n_out.page     = PAGE_W'(n_page);
            n_out.pos_x    = place_x[POSX_W-1:0];
            n_out.pos_y    = place_y;
            n_out.new_page = page_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shelf_x   <= '0;
            r_shelf_y   <= '0;
            r_shelf_h   <= '0;
            r_page      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire && !i_cls.blank) begin
                r_shelf_x <= n_shelf_x;
                r_shelf_y <= n_shelf_y;
                r_shelf_h <= n_shelf_h;
                r_page    <= n_page;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.page        = r_out.page;
    assign o_out.pos_x       = r_out.pos_x;
    assign o_out.pos_y       = r_out.pos_y;
    assign o_out.cell_width  = r_out.cell_width;
    assign o_out.cell_height = r_out.cell_height;
    assign o_out.y_offset    = r_out.y_offset;
    assign o_out.advance_px  = r_out.advance_px;
    assign o_out.new_page    = r_out.new_page;
    assign o_out.blank       = r_out.blank;

    a_new_page_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.new_page |-> (r_out.pos_x == '0) && (r_out.pos_y == '0))
        else $error("new page not placed at origin");

    a_blank_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.blank |-> (r_out.cell_width == '0) && !r_out.new_page)
        else $error("blank glyph took a cell");

    a_page_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_page >= $past(r_page))
        else $error("page index went backward");

endmodule

// ===== src/glyph_shelf_atlas_packer.sv =====
// channel   dir  handshake          payload
// i_in      in   valid/ready        glyph_width, glyph_height, bearing_top, advance_raw
// o_out     out  valid/ready        page, pos_x, pos_y, cell_width, cell_height,
//                                   y_offset, advance_px, new_page, blank
// i_cfg_*   in   write enable only  i_cfg_idx selects register, i_cfg_data value
//
// one glyph per cycle sustained while o_out is ready; an input beat is written into the
// two-entry queue, then the placement stage registers it into the output register
// the placement stage (shelf add/compare chain on the shelf registers) sets the clock
// reset is synchronous active low; it clears shelf, page and queue state
// a stalled output fills the queue, then i_in.ready drops

module glyph_shelf_atlas_packer #(
    parameter int MAX_ATLAS_DIM = gsap_pkg::MAX_ATLAS_DIM_DEF,
    parameter int PAGE_BITS     = gsap_pkg::PAGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    glyph_in_if.sink                          i_in,
    place_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [gsap_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gsap_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gsap_pkg::*;

    t_cfg    r_cfg;
    t_cls    front_cls, back_cls;
    t_q_stat q_stat;
    logic    push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ascender     <= '0;
            r_cfg.line_height  <= '0;
            r_cfg.atlas_width  <= DIM_RESET;
            r_cfg.atlas_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ASCENDER:     r_cfg.ascender     <= i_cfg_data[ASC_W-1:0];
                CFG_LINE_HEIGHT:  r_cfg.line_height  <= i_cfg_data[LH_W-1:0];
                CFG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_data[DIM_W-1:0];
                CFG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_data[DIM_W-1:0];
            endcase
        end
    end

    gsap_front u_front (
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cls    (front_cls)
    );

    gsap_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_data  (back_cls),
        .o_stat  (q_stat)
    );

    gsap_back #(
        .MAX_ATLAS_DIM (MAX_ATLAS_DIM),
        .PAGE_BITS     (PAGE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_cls    (back_cls),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gsap_pkg::*;

    localparam int STALL_CYCLES   = 100;
    localparam int STALL_AFTER    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_GLYPHS   = 160;

    typedef struct packed {
        logic [GW_W-1:0]         glyph_width;
        logic [GH_W-1:0]         glyph_height;
        logic signed [BT_W-1:0]  bearing_top;
        logic [ADV_W-1:0]        advance_raw;
    } t_glyph;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    glyph_in_if  in_ch();
    place_out_if out_ch();

    glyph_shelf_atlas_packer DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // packer state and registers as the block should hold them
    logic [ASC_W-1:0]  pk_ascender  = '0;
    logic [LH_W-1:0]   pk_line_h    = '0;
    logic [DIM_W-1:0]  pk_atlas_w   = DIM_RESET;
    logic [DIM_W-1:0]  pk_atlas_h   = DIM_RESET;
    logic [DIM_W-1:0]  pk_shelf_x   = '0;
    logic [DIM_W-1:0]  pk_shelf_y   = '0;
    logic [DIM_W-1:0]  pk_shelf_h   = '0;
    logic [PAGE_W-1:0] pk_page      = '0;

    t_glyph glyphs_to_send[$];
    t_res   placements_due[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned idle_cycles    = 0;
    int unsigned stall_left     = 0;
    logic        stall_done     = 1'b0;
    logic        steady         = 1'b0;
    logic        in_took        = 1'b0;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v < MIN_ATLAS_DIM)
            return MIN_ATLAS_DIM;
        if (v > MAX_ATLAS_DIM_DEF)
            return MAX_ATLAS_DIM_DEF;
        return v;
    endfunction

    function automatic t_res place_glyph(t_glyph g);
        t_res        r;
        int          yo;
        int unsigned y_off;
        int unsigned cell_h;
        int unsigned aw;
        int unsigned ah;
        int unsigned ny;
        r = '0;
        r.advance_px = ADVPX_W'((32'(g.advance_raw) + 63) >> 6);
        yo = int'(pk_ascender) - int'(g.bearing_top);
        y_off = (yo < 0) ? 0 : yo;
        aw = clamp_dim(pk_atlas_w);
        ah = clamp_dim(pk_atlas_h);
        if (g.glyph_width == 0 || g.glyph_height == 0) begin
            r.page = pk_page;
            r.cell_height = CELLH_W'(pk_line_h);
            r.blank = 1'b1;
            return r;
        end
        cell_h = y_off + g.glyph_height;
        if (cell_h < pk_line_h)
            cell_h = pk_line_h;
        // row full: open a shelf below the tallest cell, or a fresh page
        if (pk_shelf_x + g.glyph_width >= aw - 1) begin
            ny = pk_shelf_y + pk_shelf_h + 1;
            pk_shelf_h = '0;
            pk_shelf_x = '0;
            if (ny + cell_h >= ah - 1) begin
                if (pk_page != '1)
                    pk_page = pk_page + 1'b1;
                ny = 0;
                r.new_page = 1'b1;
            end
            pk_shelf_y = DIM_W'(ny);
        end
        r.page = pk_page;
        r.pos_x = POSX_W'(pk_shelf_x);
        r.pos_y = POSY_W'(pk_shelf_y);
        pk_shelf_x = DIM_W'(pk_shelf_x + g.glyph_width);
        if (pk_shelf_h < cell_h)
            pk_shelf_h = DIM_W'(cell_h);
        r.cell_width = g.glyph_width;
        r.cell_height = CELLH_W'(cell_h);
        r.y_offset = YOFF_W'(y_off);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_config(int unsigned asc, int unsigned lh, int unsigned aw,
                              int unsigned ah);
        write_reg(CFG_ASCENDER, asc);
        write_reg(CFG_LINE_HEIGHT, lh);
        write_reg(CFG_ATLAS_WIDTH, aw);
        write_reg(CFG_ATLAS_HEIGHT, ah);
    endtask

    task automatic add_glyph(int unsigned gw, int unsigned gh, int bt, int unsigned adv);
        t_glyph g;
        g.glyph_width  = GW_W'(gw);
        g.glyph_height = GH_W'(gh);
        g.bearing_top  = BT_W'(bt);
        g.advance_raw  = ADV_W'(adv);
        glyphs_to_send = {glyphs_to_send, g};
    endtask

    task automatic settle();
        while (glyphs_to_send.size() != 0 || placements_due.size() != 0 || in_ch.valid)
            @(negedge clk);
    endtask

    // glyph sender
    always @(negedge clk) begin : drive_glyphs
        logic offer;
        offer = 1'b0;
        if (rst_n && glyphs_to_send.size() != 0)
            offer = (in_ch.valid && !in_took) || steady || ($urandom_range(0, 99) >= 34);
        in_ch.valid <= offer;
        if (offer) begin
            in_ch.glyph_width  <= glyphs_to_send[0].glyph_width;
            in_ch.glyph_height <= glyphs_to_send[0].glyph_height;
            in_ch.bearing_top  <= glyphs_to_send[0].bearing_top;
            in_ch.advance_raw  <= glyphs_to_send[0].advance_raw;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AFTER) begin
            out_ch.ready <= 1'b0;
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge clk) begin : watch_beats
        t_res   want;
        t_glyph g;
        if (!rst_n) begin
            in_took <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_ASCENDER:     pk_ascender = ASC_W'(cfg_data);
                    CFG_LINE_HEIGHT:  pk_line_h   = LH_W'(cfg_data);
                    CFG_ATLAS_WIDTH:  pk_atlas_w  = cfg_data;
                    CFG_ATLAS_HEIGHT: pk_atlas_h  = cfg_data;
                    default: ;
                endcase
            end
            in_took <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                g.glyph_width  = in_ch.glyph_width;
                g.glyph_height = in_ch.glyph_height;
                g.bearing_top  = in_ch.bearing_top;
                g.advance_raw  = in_ch.advance_raw;
                void'(glyphs_to_send.pop_front());
                placements_due = {placements_due, place_glyph(g)};
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (placements_due.size() == 0) begin
                    $error("result beat with no glyph outstanding");
                    mismatch_count++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("page", want.page, out_ch.page);
                    check_field("pos_x", want.pos_x, out_ch.pos_x);
                    check_field("pos_y", want.pos_y, out_ch.pos_y);
                    check_field("cell_width", want.cell_width, out_ch.cell_width);
                    check_field("cell_height", want.cell_height, out_ch.cell_height);
                    check_field("y_offset", want.y_offset, out_ch.y_offset);
                    check_field("advance_px", want.advance_px, out_ch.advance_px);
                    check_field("new_page", want.new_page, out_ch.new_page);
                    check_field("blank", want.blank, out_ch.blank);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : run
        t_glyph      g;
        int unsigned pick;
        int          phase;
        int          n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ASCENDER;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.glyph_width = '0;
        in_ch.glyph_height = '0;
        in_ch.bearing_top = '0;
        in_ch.advance_raw = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // small page so rows, shelves and pages turn over quickly
        set_config(20, 24, 64, 64);
        add_glyph(10, 10, 20, 0);
        add_glyph(0, 30, 5, 32767);         // blank by width, largest advance
        add_glyph(30, 0, -128, 64);         // blank by height
        add_glyph(255, 255, -128, 1);       // cell larger than the page
        add_glyph(255, 1, 127, 65);         // bearing above ascender, offset floors at zero
        repeat (10) add_glyph(12, 12, 8, 640);
        add_glyph(1, 1, 0, 63);
        add_glyph(1, 255, 0, 32704);
        add_glyph(200, 8, -1, 100);
        add_glyph(0, 0, -128, 32767);
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_config(255, 255, 512, 512);
                2, 7: set_config(0, 0, 16, 16);
                3: set_config($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 1023), $urandom_range(0, 1023));
                4: set_config(128, 0, 1023, 1023);
                6: set_config(10, 12, 0, 8);
                default: set_config($urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(16, 512), $urandom_range(16, 512));
            endcase
            steady = (phase == 1);
            for (n = 0; n < PHASE_GLYPHS; n++) begin
                pick = $urandom_range(0, 99);
                g.glyph_width  = GW_W'($urandom);
                g.glyph_height = GH_W'($urandom);
                g.bearing_top  = BT_W'($urandom);
                g.advance_raw  = ADV_W'($urandom);
                if (pick < 10) begin
                    if (pick < 5)
                        g.glyph_width = '0;
                    else
                        g.glyph_height = '0;
                end else if (pick < 75) begin
                    // typical text sizes so many glyphs share a row
                    g.glyph_width  = GW_W'($urandom_range(1, 40));
                    g.glyph_height = GH_W'($urandom_range(1, 40));
                    g.bearing_top  = BT_W'(int'($urandom_range(0, 40)) - 8);
                end
                glyphs_to_send = {glyphs_to_send, g};
            end
            settle();
        end
        steady = 1'b0;

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
